/* src/spbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbl_pkg
// Shared types and constants for the slot pool with bucket lists.
// ----------------------------------------------------------------------------
package spbl_pkg;

  localparam int unsigned NumSlots   = 1024;
  localparam int unsigned NumBuckets = 4096;
  localparam int unsigned IdentBits  = 32;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned SlotFW   = 10;
  localparam int unsigned BucketFW = 12;
  localparam int unsigned GrantFW  = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountFW  = 11;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 3'd0,
    MODE_FREE    = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_INSERT  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [IdentBits-1:0] ident;
    logic [SlotFW-1:0]    slot;
    logic [BucketFW-1:0]  bucket;
  } in_t;

  typedef struct packed {
    logic [GrantFW-1:0] granted_slot;
    logic [StatusW-1:0] status;
    logic [CountFW-1:0] live_count;
  } out_t;

endpackage

/* src/slot_pool_with_bucket_lists.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_with_bucket_lists
// Slot allocator with free list, bump pointer and doubly linked bucket lists.
// ----------------------------------------------------------------------------
// Sequence: each item is accepted in idle, executed, and its result is
//   registered in the response state; insert, delete and release may pass
//   through link, delete or walk states first.
// Flow: in_stall_o stays high until the result is registered, so a new item
//   is taken only once the last is done; slot memory has one read, one write port.
// Reset: bucket-head memory is swept to null, one entry a cycle, with
//   in_stall_o high; control registers reset at once, data registers do not.
module slot_pool_with_bucket_lists
  import spbl_pkg::*;
#(
  parameter int unsigned SLOTS   = NumSlots,
  parameter int unsigned BUCKETS = NumBuckets
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam int unsigned BktW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WordW = IdentBits + 1 + 2 * LinkW;

  logic             sm_we;
  logic [SlotW-1:0] sm_waddr, sm_raddr;
  logic [WordW-1:0] sm_wdata, sm_rdata;
  logic             bm_we;
  logic [BktW-1:0]  bm_waddr, bm_raddr;
  logic [LinkW-1:0] bm_wdata, bm_rdata;

  spbl_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  spbl_ram #(
    .Width (LinkW),
    .Depth (BUCKETS)
  ) u_bucket_mem (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  spbl_engine #(
    .SLOTS   (SLOTS),
    .BUCKETS (BUCKETS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .sm_we_o     (sm_we),
    .sm_waddr_o  (sm_waddr),
    .sm_wdata_o  (sm_wdata),
    .sm_raddr_o  (sm_raddr),
    .sm_rdata_i  (sm_rdata),
    .bm_we_o     (bm_we),
    .bm_waddr_o  (bm_waddr),
    .bm_wdata_o  (bm_wdata),
    .bm_raddr_o  (bm_raddr),
    .bm_rdata_i  (bm_rdata)
  );

endmodule

/* src/spbl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbl_ram
// Generic simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spbl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/spbl_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbl_engine
// Operation sequencer: read-modify-write of slot and bucket-head memories,
// free list and bump pointer, result register.
// ----------------------------------------------------------------------------
module spbl_engine
  import spbl_pkg::*;
#(
  parameter int unsigned SLOTS   = NumSlots,
  parameter int unsigned BUCKETS = NumBuckets,
  localparam int unsigned SlotW  = $clog2(SLOTS),
  localparam int unsigned LinkW  = $clog2(SLOTS + 1),
  localparam int unsigned BktW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int unsigned WordW  = IdentBits + 1 + 2 * LinkW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o,
  output logic             sm_we_o,
  output logic [SlotW-1:0] sm_waddr_o,
  output logic [WordW-1:0] sm_wdata_o,
  output logic [SlotW-1:0] sm_raddr_o,
  input  logic [WordW-1:0] sm_rdata_i,
  output logic             bm_we_o,
  output logic [BktW-1:0]  bm_waddr_o,
  output logic [LinkW-1:0] bm_wdata_o,
  output logic [BktW-1:0]  bm_raddr_o,
  input  logic [LinkW-1:0] bm_rdata_i
);

  localparam logic [LinkW-1:0] NullLink = LinkW'(SLOTS);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_EXEC = 8'b0000_0100,
    S_WALK = 8'b0000_1000,
    S_LINK = 8'b0001_0000,
    S_DELP = 8'b0010_0000,
    S_DELN = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  in_t              op_q, op_d;
  logic [LinkW-1:0] free_head_q, free_head_d;
  logic [LinkW-1:0] bump_q, bump_d;
  logic [LinkW-1:0] count_q, count_d;
  logic [BktW-1:0]  clr_q, clr_d;
  logic [LinkW-1:0] nb_p_q, nb_p_d;
  logic [LinkW-1:0] nb_n_q, nb_n_d;
  logic [SlotW-1:0] rd_slot_q;
  logic [SlotW-1:0] gs_q, gs_d;
  status_e          st_q, st_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic                 s_ok, b_ok, vld, do_walk;
  logic [SlotW-1:0]     op_s;
  logic [LinkW-1:0]     op_link, rd_link, count_dec;
  logic [BktW-1:0]      op_b;
  logic [IdentBits-1:0] w_ident;
  logic                 w_used;
  logic [LinkW-1:0]     w_next, w_prev;

  assign s_ok      = 32'(op_q.slot) < 32'(SLOTS);
  assign b_ok      = 32'(op_q.bucket) < 32'(BUCKETS);
  assign op_s      = SlotW'(op_q.slot);
  assign op_link   = LinkW'(op_q.slot);
  assign op_b      = BktW'(op_q.bucket);
  assign rd_link   = LinkW'(rd_slot_q);
  assign count_dec = (count_q != '0) ? (count_q - LinkW'(1)) : count_q;

  // entries at or above the bump pointer were never handed out: reset view
  assign vld     = rd_link < bump_q;
  assign w_ident = sm_rdata_i[WordW-1 -: IdentBits];
  assign w_used  = vld & sm_rdata_i[2*LinkW];
  assign w_next  = vld ? sm_rdata_i[2*LinkW-1 -: LinkW] : NullLink;
  assign w_prev  = vld ? sm_rdata_i[LinkW-1:0] : NullLink;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    free_head_d = free_head_q;
    bump_d      = bump_q;
    count_d     = count_q;
    clr_d       = clr_q;
    nb_p_d      = nb_p_q;
    nb_n_d      = nb_n_q;
    gs_d        = gs_q;
    st_d        = st_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    sm_we_o     = 1'b0;
    sm_waddr_o  = rd_slot_q;
    sm_wdata_o  = {w_ident, w_used, w_next, w_prev};
    sm_raddr_o  = rd_slot_q;
    bm_we_o     = 1'b0;
    bm_waddr_o  = op_b;
    bm_wdata_o  = NullLink;
    bm_raddr_o  = op_b;
    do_walk     = 1'b0;

    unique case (state_q)
      S_CLR: begin
        bm_we_o    = 1'b1;
        bm_waddr_o = clr_q;
        bm_wdata_o = NullLink;
        clr_d      = clr_q + BktW'(1);
        if (clr_q == BktW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        sm_raddr_o = (in_i.mode == MODE_ALLOC) ? SlotW'(free_head_q) : SlotW'(in_i.slot);
        bm_raddr_o = BktW'(in_i.bucket);
        if (in_valid_i) begin
          op_d    = in_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        gs_d    = '0;
        st_d    = ST_OK;
        state_d = S_RESP;
        case (op_q.mode)
          MODE_ALLOC: begin
            if (free_head_q < NullLink) begin
              sm_we_o     = 1'b1;
              sm_waddr_o  = SlotW'(free_head_q);
              sm_wdata_o  = {op_q.ident, 1'b1, w_next, w_prev};
              free_head_d = w_next;
              count_d     = count_q + LinkW'(1);
              gs_d        = SlotW'(free_head_q);
            end else if (bump_q < NullLink) begin
              sm_we_o    = 1'b1;
              sm_waddr_o = SlotW'(bump_q);
              sm_wdata_o = {op_q.ident, 1'b1, NullLink, NullLink};
              bump_d     = bump_q + LinkW'(1);
              count_d    = count_q + LinkW'(1);
              gs_d       = SlotW'(bump_q);
            end else begin
              st_d = ST_FULL;
            end
          end
          MODE_FREE: begin
            if (s_ok && w_used) begin
              sm_we_o     = 1'b1;
              sm_waddr_o  = op_s;
              sm_wdata_o  = {w_ident, 1'b0, free_head_q, w_prev};
              free_head_d = op_link;
              count_d     = count_dec;
            end else begin
              st_d = ST_UNUSED;
            end
          end
          MODE_RELEASE: begin
            if (s_ok && w_used) begin
              do_walk = 1'b1;
            end else begin
              st_d = ST_UNUSED;
            end
          end
          MODE_INSERT: begin
            if (!(s_ok && w_used)) begin
              st_d = ST_UNUSED;
            end else if (b_ok) begin
              bm_we_o    = 1'b1;
              bm_waddr_o = op_b;
              bm_wdata_o = op_link;
              sm_we_o    = 1'b1;
              sm_waddr_o = op_s;
              if (bm_rdata_i == op_link) begin
                sm_wdata_o = {w_ident, w_used, op_link, op_link};
              end else begin
                sm_wdata_o = {w_ident, w_used, bm_rdata_i, NullLink};
                if (bm_rdata_i < NullLink) begin
                  sm_raddr_o = SlotW'(bm_rdata_i);
                  state_d    = S_LINK;
                end
              end
            end
          end
          MODE_DELETE: begin
            if (!s_ok) begin
              st_d = ST_UNUSED;
            end else begin
              nb_p_d = w_prev;
              nb_n_d = w_next;
              if (w_prev < NullLink) begin
                sm_raddr_o = SlotW'(w_prev);
                state_d    = S_DELP;
              end else begin
                if (b_ok) begin
                  bm_we_o    = 1'b1;
                  bm_waddr_o = op_b;
                  bm_wdata_o = w_next;
                end
                if (w_next < NullLink) begin
                  sm_raddr_o = SlotW'(w_next);
                  state_d    = S_DELN;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (w_used) begin
          do_walk = 1'b1;
        end else begin
          state_d = S_RESP;
        end
      end
      S_LINK: begin
        sm_we_o    = 1'b1;
        sm_wdata_o = {w_ident, w_used, w_next, op_link};
        state_d    = S_RESP;
      end
      S_DELP: begin
        sm_we_o = 1'b1;
        state_d = S_RESP;
        if (nb_n_q == nb_p_q) begin
          sm_wdata_o = {w_ident, w_used, nb_n_q, nb_p_q};
        end else begin
          sm_wdata_o = {w_ident, w_used, nb_n_q, w_prev};
          if (nb_n_q < NullLink) begin
            sm_raddr_o = SlotW'(nb_n_q);
            state_d    = S_DELN;
          end
        end
      end
      S_DELN: begin
        sm_we_o    = 1'b1;
        sm_wdata_o = {w_ident, w_used, w_next, nb_p_q};
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.granted_slot = GrantFW'(gs_q);
          out_d.status       = st_q;
          out_d.live_count   = CountFW'(count_q);
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one chain slot per cycle: free it, fetch its successor
    if (do_walk) begin
      sm_we_o     = 1'b1;
      sm_waddr_o  = rd_slot_q;
      sm_wdata_o  = {w_ident, 1'b0, free_head_q, w_prev};
      free_head_d = rd_link;
      count_d     = count_dec;
      if ((w_next < NullLink) && (w_next != rd_link)) begin
        sm_raddr_o = SlotW'(w_next);
        state_d    = S_WALK;
      end else begin
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      free_head_q <= NullLink;
      bump_q      <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      bump_q      <= bump_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    nb_p_q    <= nb_p_d;
    nb_n_q    <= nb_n_d;
    rd_slot_q <= sm_raddr_o;
    gs_q      <= gs_d;
    st_q      <= st_d;
    out_q     <= out_d;
  end

endmodule
